### rtl/lfr_pkg.sv
`default_nettype none

package lfr_pkg;

  localparam int LONG_LAG  = 55;
  localparam int SHORT_LAG = 24;
  localparam int PTR_W     = (LONG_LAG > 1) ? $clog2(LONG_LAG) : 1;

  localparam int WORD_W    = 31;
  localparam int INDEX_W   = 6;
  localparam int DIV_W     = WORD_W + 1;
  localparam int DIV_STEPS = DIV_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_RANGE = 2'd1;

  localparam logic [WORD_W-1:0] MODULUS_RESET    = 31'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] PICK_RANGE_RESET = 31'd1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  // one slot of the remainder chain
  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] div;
  } stage_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MOD,
    ST_PICK,
    ST_DONE
  } state_e;

  // a zero register value stands for 2^31
  function automatic logic [DIV_W-1:0] to_divisor(logic [WORD_W-1:0] m);
    logic [DIV_W-1:0] d;
    if (m == '0) begin
      d = {1'b1, {WORD_W{1'b0}}};
    end else begin
      d = {1'b0, m};
    end
    return d;
  endfunction

  function automatic logic [PTR_W-1:0] step_down(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == '0) begin
      n = PTR_W'(LONG_LAG - 1);
    end else begin
      n = p - PTR_W'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/lfr_ram.sv
`default_nettype none

module lfr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 55
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

### rtl/lfr_mod_cell.sv
`default_nettype none

module lfr_mod_cell
  import lfr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire stage_t st_i,
  output stage_t      st_o
);

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [DIV_W-1:0] rem_d;

  logic             valid_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] num_q;
  logic [DIV_W-1:0] div_q;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {st_i.rem, st_i.num[DIV_W-1]};
    diff  = trial - {1'b0, st_i.div};
    fits  = (trial >= {1'b0, st_i.div});
    rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= st_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= {st_i.num[DIV_W-2:0], 1'b0};
    div_q <= st_i.div;
  end

  assign st_o = '{valid: valid_q, rem: rem_q, num: num_q, div: div_q};

endmodule

`default_nettype wire

### rtl/lagged_fibonacci_rng.sv
// Additive lagged Fibonacci generator. A load word (kind 0) writes one seed
// into the 55-word ring and gives no result; every slot
// the draws will touch must be loaded first. A draw word (kind 1) reads the
// two lagged words, reduces their sum modulo the modulus register, writes
// the new word back, and returns it together with that word modulo
// pick_range. A draw occupies the block for one ring read, two passes
// through the 32-cell remainder chain (one for the modulus, one for the
// pick range), and a hand-off that waits for a free output slot. The
// next word is taken while a finished result still waits on the output.
// A register value of zero for either divisor acts as 2^31. Write the
// configuration only while no draw is in flight.
`default_nettype none

module lagged_fibonacci_rng
  import lfr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 kind_i,
  input  wire logic [INDEX_W-1:0]   load_index_i,
  input  wire logic [WORD_W-1:0]    load_value_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [WORD_W-1:0]    value_o,
  output logic      [WORD_W-1:0]    pick_o
);

  state_e state_q, state_d;

  logic [WORD_W-1:0] modulus_q, pick_range_q;
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [WORD_W-1:0] word_q, pick_q;
  logic [WORD_W-1:0] out_value_q, out_pick_q;
  logic              out_valid_q;

  logic              in_fire, slot_free, idx_ok;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ring_a, ring_b;
  logic [DIV_W-1:0]  sum;

  stage_t chain_w [DIV_STEPS+1];
  stage_t launch;
  stage_t chain_out;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign idx_ok      = (int'(load_index_i) < LONG_LAG);
  assign sum         = {1'b0, ring_a} + {1'b0, ring_b};
  assign chain_out   = chain_w[DIV_STEPS];

  lfr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LONG_LAG)
  ) u_ring (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (wr_ptr_q),
    .raddr_b_i (rd_ptr_q),
    .rdata_a_o (ring_a),
    .rdata_b_o (ring_b)
  );

  assign chain_w[0] = launch;

  for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_cell
    lfr_mod_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .st_i   (chain_w[gi]),
      .st_o   (chain_w[gi+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && kind_i == KIND_DRAW) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_MOD;
      ST_MOD: begin
        if (chain_out.valid) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (chain_out.valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = wr_ptr_q;
    ram_wdata    = chain_out.rem[WORD_W-1:0];
    launch.valid = 1'b0;
    launch.rem   = '0;
    launch.num   = sum;
    launch.div   = to_divisor(modulus_q);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_waddr  = PTR_W'(load_index_i);
        ram_wdata  = load_value_i;
        ram_we     = in_fire && kind_i == KIND_LOAD && idx_ok;
      end
      ST_READ: begin
        launch.valid = 1'b1;
      end
      ST_MOD: begin
        // reduced word goes back to the ring and straight into the pick pass
        ram_we       = chain_out.valid;
        launch.valid = chain_out.valid;
        launch.num   = {1'b0, chain_out.rem[WORD_W-1:0]};
        launch.div   = to_divisor(pick_range_q);
      end
      ST_PICK, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      modulus_q    <= MODULUS_RESET;
      pick_range_q <= PICK_RANGE_RESET;
      wr_ptr_q     <= PTR_W'(SHORT_LAG - 1);
      rd_ptr_q     <= PTR_W'(LONG_LAG - 1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_MODULUS) begin
          modulus_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_PICK_RANGE) begin
          pick_range_q <= cfg_data_i;
        end
      end
      if (state_q == ST_MOD && chain_out.valid) begin
        wr_ptr_q <= step_down(wr_ptr_q);
        rd_ptr_q <= step_down(rd_ptr_q);
      end
      if (state_q == ST_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MOD && chain_out.valid) begin
      word_q <= chain_out.rem[WORD_W-1:0];
    end
    if (state_q == ST_PICK && chain_out.valid) begin
      pick_q <= chain_out.rem[WORD_W-1:0];
    end
    if (state_q == ST_DONE && slot_free) begin
      out_value_q <= word_q;
      out_pick_q  <= pick_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign pick_o      = out_pick_q;

`ifndef SYNTHESIS
  a_chain_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_out.valid |-> (state_q == ST_MOD || state_q == ST_PICK))
    else $error("remainder chain output outside a reduction pass");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised without a finished draw");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(wr_ptr_q) < LONG_LAG) && (int'(rd_ptr_q) < LONG_LAG))
    else $error("ring pointer out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((int'(rd_ptr_q) - int'(wr_ptr_q) + LONG_LAG) % LONG_LAG) == (LONG_LAG - SHORT_LAG))
    else $error("ring pointers lost their lag distance");
`endif

endmodule

`default_nettype wire

### bench/lagged_fibonacci_rng_test.sv
`default_nettype none

module lagged_fibonacci_rng_test;
  import lfr_pkg::*;

  localparam int SETTLE_CYCLES = 80;    // margin for one draw end to end
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 110;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_PRINTS    = 40;

  // index with no register behind it; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_DRAW,
    ROW_CFG
  } row_op_e;

  typedef struct packed {
    row_op_e              op;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [INDEX_W-1:0]   slot;
    logic [WORD_W-1:0]    word;
    logic                 known;
    logic [WORD_W-1:0]    want_value;
    logic [WORD_W-1:0]    want_pick;
  } plan_row_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] pick;
  } draw_t;

  // pointers start at 23 (write) and 54 (read) and step down once per draw
  localparam plan_row_t PLAN [24] = '{
    '{ROW_LOAD, CFG_MODULUS,    6'd23, 31'h7FFF_FFFE, 1'b0, '0, '0},
    '{ROW_LOAD, CFG_MODULUS,    6'd54, 31'h7FFF_FFFE, 1'b0, '0, '0},
    '{ROW_LOAD, CFG_MODULUS,    6'd63, 31'h0000_0000, 1'b0, '0, '0},  // out of range
    '{ROW_LOAD, CFG_MODULUS,    6'd55, 31'h7FFF_FFFF, 1'b0, '0, '0},  // out of range
    '{ROW_DRAW, CFG_MODULUS,    6'd63, 31'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFD, 31'd0},
    '{ROW_LOAD, CFG_MODULUS,    6'd22, 31'h7FFF_FFFF, 1'b0, '0, '0},  // seed == modulus
    '{ROW_LOAD, CFG_MODULUS,    6'd53, 31'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_DRAW, CFG_MODULUS,    6'd0,  31'h0000_0000, 1'b1, 31'd0, 31'd0},  // twice modulus
    '{ROW_CFG,  CFG_MODULUS,    6'd0,  31'h0000_0000, 1'b0, '0, '0},  // acts as 2^31
    '{ROW_LOAD, CFG_MODULUS,    6'd21, 31'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_LOAD, CFG_MODULUS,    6'd52, 31'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_DRAW, CFG_MODULUS,    6'd0,  31'h0000_0000, 1'b1, 31'h7FFF_FFFE, 31'd0},
    '{ROW_CFG,  CFG_PICK_RANGE, 6'd0,  31'h0000_0000, 1'b0, '0, '0},  // pick == value
    '{ROW_DRAW, CFG_MODULUS,    6'd0,  31'h0000_0000, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_MODULUS,    6'd0,  31'h0000_0001, 1'b0, '0, '0},
    '{ROW_DRAW, CFG_MODULUS,    6'd0,  31'h0000_0000, 1'b1, 31'd0, 31'd0},
    '{ROW_CFG,  CFG_MODULUS,    6'd0,  31'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_PICK_RANGE, 6'd0,  31'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_LOAD, CFG_MODULUS,    6'd0,  31'h2AAA_AAAA, 1'b0, '0, '0},
    '{ROW_DRAW, CFG_MODULUS,    6'd0,  31'h0000_0000, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_PICK_RANGE, 6'd0,  31'd10,        1'b0, '0, '0},
    '{ROW_DRAW, CFG_MODULUS,    6'd0,  31'h0000_0000, 1'b0, '0, '0},
    '{ROW_CFG,  CFG_SPARE,      6'd0,  31'h5555_5555, 1'b0, '0, '0},
    '{ROW_DRAW, CFG_MODULUS,    6'd0,  31'h0000_0000, 1'b0, '0, '0}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [WORD_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 kind_i;
  logic [INDEX_W-1:0]   load_index_i;
  logic [WORD_W-1:0]    load_value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [WORD_W-1:0]    value_o;
  logic [WORD_W-1:0]    pick_o;

  lagged_fibonacci_rng dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .load_index_i (load_index_i),
    .load_value_i (load_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .pick_o       (pick_o)
  );

  // generator copy kept in step with the block
  logic [WORD_W-1:0] lag_words [LONG_LAG];
  int unsigned       near_tap;
  int unsigned       far_tap;
  logic [WORD_W-1:0] modulus_reg;
  logic [WORD_W-1:0] pick_reg;

  draw_t draws_due [$];
  int    error_count;
  int    results_seen;
  bit    calm;
  bit    long_hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [WORD_W-1:0] wrap_mod(logic [31:0] x, logic [WORD_W-1:0] m);
    if (m == '0) begin
      return x[WORD_W-1:0];
    end
    return WORD_W'(x % {1'b0, m});
  endfunction

  function automatic int pause_len();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // advance the generator for one accepted word and queue what a draw must give
  task automatic advance_generator(input logic kind, input logic [INDEX_W-1:0] slot,
                                   input logic [WORD_W-1:0] word, input logic known,
                                   input logic [WORD_W-1:0] want_value,
                                   input logic [WORD_W-1:0] want_pick);
    logic [31:0] sum;
    draw_t       d;
    if (kind == KIND_LOAD) begin
      if (slot < LONG_LAG) begin
        lag_words[slot] = word;
      end
    end else begin
      sum = {1'b0, lag_words[near_tap]} + {1'b0, lag_words[far_tap]};
      d.value = wrap_mod(sum, modulus_reg);
      d.pick  = wrap_mod({1'b0, d.value}, pick_reg);
      lag_words[near_tap] = d.value;
      near_tap = (near_tap == 0) ? LONG_LAG - 1 : near_tap - 1;
      far_tap  = (far_tap == 0) ? LONG_LAG - 1 : far_tap - 1;
      if (known) begin
        d.value = want_value;
        d.pick  = want_pick;
      end
      draws_due.push_back(d);
    end
  endtask

  // called just after a falling edge
  task automatic send_word(input logic kind, input logic [INDEX_W-1:0] slot,
                           input logic [WORD_W-1:0] word, input logic known,
                           input logic [WORD_W-1:0] want_value,
                           input logic [WORD_W-1:0] want_pick);
    int gap;
    in_valid_i   = 1'b1;
    kind_i       = kind;
    load_index_i = slot;
    load_value_i = word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_generator(kind, slot, word, known, want_value, want_pick);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    gap = pause_len();
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_MODULUS) begin
      modulus_reg = data;
    end else if (idx == CFG_PICK_RANGE) begin
      pick_reg = data;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // wait out every pending draw, then the block's own latency
  task automatic settle();
    while (draws_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // result side
  always @(posedge clk_i) begin
    draw_t d;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (draws_due.size() == 0) begin
        flag_error($sformatf("unexpected word value=%h pick=%h", value_o, pick_o));
      end else begin
        d = draws_due.pop_front();
        if (value_o !== d.value) begin
          flag_error($sformatf("value got %h want %h", value_o, d.value));
        end
        if (pick_o !== d.pick) begin
          flag_error($sformatf("pick got %h want %h", pick_o, d.pick));
        end
      end
    end
  end

  initial begin
    int hold;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = 0;
      if (!long_hold_done && results_seen >= 30) begin
        // long back-pressure: the block fills and must stall its input
        long_hold_done = 1'b1;
        hold = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 599) == 0) begin
        hold = $urandom_range(100, 250);
      end else begin
        hold = pause_len();
      end
      if (hold > 0) begin
        out_ready_i = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic              kind;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] new_mod;
    logic [WORD_W-1:0] new_pick;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_MODULUS;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_LOAD;
    load_index_i   = '0;
    load_value_i   = '0;
    error_count    = 0;
    results_seen   = 0;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    for (int i = 0; i < LONG_LAG; i++) begin
      lag_words[i] = '0;
    end
    near_tap    = SHORT_LAG - 1;
    far_tap     = LONG_LAG - 1;
    modulus_reg = MODULUS_RESET;
    pick_reg    = PICK_RANGE_RESET;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every slot gets a seed before the first draw reads it
    for (int i = 0; i < LONG_LAG; i++) begin
      send_word(KIND_LOAD, INDEX_W'(i), WORD_W'($urandom_range(0, MODULUS_RESET - 1)),
                1'b0, '0, '0);
    end

    foreach (PLAN[i]) begin
      case (PLAN[i].op)
        ROW_CFG: begin
          settle();
          write_reg(PLAN[i].reg_sel, PLAN[i].word);
        end
        ROW_LOAD: begin
          send_word(KIND_LOAD, PLAN[i].slot, PLAN[i].word, 1'b0, '0, '0);
        end
        default: begin
          send_word(KIND_DRAW, PLAN[i].slot, PLAN[i].word, PLAN[i].known,
                    PLAN[i].want_value, PLAN[i].want_pick);
        end
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          new_mod  = MODULUS_RESET;
          new_pick = WORD_W'($urandom_range(1, 100));
        end
        1: begin
          new_mod  = 31'd2;
          new_pick = 31'h7FFF_FFFF;
        end
        2: begin
          new_mod  = '0;
          new_pick = '0;
        end
        3: begin
          new_mod  = WORD_W'($urandom_range(2, 32'h7FFF_FFFF));
          new_pick = WORD_W'($urandom_range(1, 32'h7FFF_FFFF));
        end
        4: begin
          new_mod  = 31'd1;
          new_pick = WORD_W'($urandom_range(1, 16));
        end
        5: begin
          new_mod  = WORD_W'($urandom_range(2, 1000));
          new_pick = WORD_W'($urandom_range(1, 50));
        end
        6: begin
          new_mod  = '0;
          new_pick = WORD_W'($urandom_range(1, 32'h7FFF_FFFF));
        end
        default: begin
          new_mod  = WORD_W'($urandom_range(2, 32'h7FFF_FFFF));
          new_pick = '0;
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_MODULUS, new_mod);
        write_reg(CFG_PICK_RANGE, new_pick);
      end else begin
        write_reg(CFG_PICK_RANGE, new_pick);
        write_reg(CFG_MODULUS, new_mod);
      end
      calm = (phase == 2) || (phase == 5);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        kind = ($urandom_range(0, 99) < 60) ? KIND_DRAW : KIND_LOAD;
        if (modulus_reg > 1 && $urandom_range(0, 3) != 0) begin
          word = WORD_W'($urandom_range(0, modulus_reg - 1));
        end else begin
          word = WORD_W'($urandom);
        end
        send_word(kind, INDEX_W'($urandom_range(0, 63)), word, 1'b0, '0, '0);
      end
    end

    calm = 1'b0;
    settle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/lfr_pkg.sv
rtl/lfr_ram.sv
rtl/lfr_mod_cell.sv
rtl/lagged_fibonacci_rng.sv
bench/lagged_fibonacci_rng_test.sv
